// ===== rtl/mqufi_pkg.sv =====
// Shared types and codes for the multi-queue urgent front-insert unit.
`timescale 1ns / 1ps

package mqufi_pkg;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned WordW  = IdW + 1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [IdxW-1:0]  queue_index;
    logic             urgent_flag;
    logic [IdW-1:0]   entry_id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IdW-1:0]     taken_id;
    logic               taken_urgent;
    logic [CountW-1:0]  queue_count;
  } rsp_t;

endpackage

// ===== rtl/multi_queue_urgent_front_insert_unit.sv =====
// Bank of bounded ring-buffer deques with tail append, urgent head insert and head take.
`timescale 1ns / 1ps

// One transaction is accepted in every cycle (busy stays low) and its result is
// presented with valid_o for exactly one cycle, in the cycle after the start. All
// queue pointers and counts are updated at the accepting edge, so back-to-back
// transactions to the same queue see each other in order. The entry store is a
// single memory written or read at most once per cycle; its read data is registered
// and forms the taken fields of the result. The receiver cannot stall the result.
module multi_queue_urgent_front_insert_unit #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mqufi_pkg::req_t   req_i,
  output logic              valid_o,
  output mqufi_pkg::rsp_t   rsp_o
);

  import mqufi_pkg::*;

  localparam int unsigned HeadW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned Words = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AddrW = $clog2(Words);

  logic [HeadW-1:0] head_q  [NUM_QUEUES];
  logic [CntW-1:0]  count_q [NUM_QUEUES];
  logic [WordW-1:0] mem_q   [Words];

  logic             accept;
  logic [QW-1:0]    q_idx;
  logic             q_valid;
  logic [HeadW-1:0] head_cur;
  logic [CntW-1:0]  cnt_cur;
  logic [HeadW:0]   tail_sum;
  logic [HeadW-1:0] tail_slot;
  logic [HeadW-1:0] head_dec;
  logic [HeadW-1:0] head_inc;
  logic [AddrW-1:0] base_addr;

  logic             upd_en;
  logic [HeadW-1:0] head_d;
  logic [CntW-1:0]  cnt_d;
  logic             wr_en;
  logic             rd_en;
  logic [HeadW-1:0] slot_sel;
  logic [AddrW-1:0] mem_addr;
  status_e          status_d;
  logic             take_ok_d;
  logic [CntW-1:0]  cnt_out_d;

  logic             valid_q;
  status_e          status_q;
  logic             take_ok_q;
  logic [CountW-1:0] rsp_cnt_q;
  logic [WordW-1:0] rd_data_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign q_idx    = QW'(req_i.queue_index);
  assign q_valid  = (32'(req_i.queue_index) < NUM_QUEUES);
  assign head_cur = head_q[q_idx];
  assign cnt_cur  = count_q[q_idx];

  // Head is below the depth and count at most the depth, so one conditional subtract wraps the tail.
  assign tail_sum  = {1'b0, head_cur} + (HeadW + 1)'(cnt_cur);
  assign tail_slot = (tail_sum >= (HeadW + 1)'(QUEUE_DEPTH))
                     ? HeadW'(tail_sum - (HeadW + 1)'(QUEUE_DEPTH))
                     : HeadW'(tail_sum);
  assign head_dec  = (head_cur == '0) ? HeadW'(QUEUE_DEPTH - 1) : head_cur - HeadW'(1);
  assign head_inc  = (head_cur == HeadW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + HeadW'(1);
  assign base_addr = AddrW'(AddrW'(q_idx) * AddrW'(QUEUE_DEPTH));
  assign mem_addr  = base_addr + AddrW'(slot_sel);

  always_comb begin
    upd_en    = 1'b0;
    head_d    = head_cur;
    cnt_d     = cnt_cur;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    slot_sel  = head_cur;
    status_d  = STATUS_DONE;
    take_ok_d = 1'b0;
    cnt_out_d = '0;
    unique case (req_i.command)
      CMD_ADD: begin
        if (!q_valid) begin
          status_d = STATUS_FULL;
        end else if (cnt_cur >= CntW'(QUEUE_DEPTH)) begin
          status_d  = STATUS_FULL;
          cnt_out_d = cnt_cur;
        end else begin
          upd_en    = 1'b1;
          wr_en     = 1'b1;
          cnt_d     = cnt_cur + CntW'(1);
          cnt_out_d = cnt_d;
          if (req_i.urgent_flag) begin
            head_d   = head_dec;
            slot_sel = head_dec;
          end else begin
            slot_sel = tail_slot;
          end
        end
      end
      CMD_TAKE: begin
        if (!q_valid || cnt_cur == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          upd_en    = 1'b1;
          rd_en     = 1'b1;
          take_ok_d = 1'b1;
          head_d    = head_inc;
          cnt_d     = cnt_cur - CntW'(1);
          cnt_out_d = cnt_d;
        end
      end
      default: begin
        status_d = STATUS_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (accept && upd_en) begin
      head_q[q_idx]  <= head_d;
      count_q[q_idx] <= cnt_d;
    end
  end

  // Entry store: at most one write or one read per transaction, read data registered.
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[mem_addr] <= {req_i.urgent_flag, req_i.entry_id};
    end
    if (accept && rd_en) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      status_q  <= STATUS_DONE;
      take_ok_q <= 1'b0;
      rsp_cnt_q <= '0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        status_q  <= status_d;
        take_ok_q <= take_ok_d;
        rsp_cnt_q <= CountW'(cnt_out_d);
      end
    end
  end

  assign valid_o            = valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.taken_id     = take_ok_q ? rd_data_q[IdW-1:0] : '0;
  assign rsp_o.taken_urgent = take_ok_q ? rd_data_q[IdW] : 1'b0;
  assign rsp_o.queue_count  = rsp_cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted transaction produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != STATUS_DONE) |-> (rsp_o.taken_id == '0 && !rsp_o.taken_urgent))
    else $error("failed operation returned taken data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == STATUS_EMPTY) |-> (rsp_o.queue_count == '0))
    else $error("empty status with nonzero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && wr_en) |-> !rd_en)
    else $error("entry store written and read by one transaction");

endmodule
